FILE: hdl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

   // Shared multiplier operand and product widths
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // CORDIC start value: the inverse of the rotation gain in Q4.30
   localparam logic signed [MUL_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // Quarter turn as a binary angle
   localparam logic signed [31:0] QUARTER_TURN     = 32'sh4000_0000;
   localparam logic signed [31:0] NEG_QUARTER_TURN = -32'sh4000_0000;
   localparam logic [31:0]        HALF_TURN        = 32'h8000_0000;

   // Distance clamp, +-2^32 in Q16.16
   localparam logic signed [48:0] DIST_HI = 49'sd4294967296;
   localparam logic signed [48:0] DIST_LO = -49'sd4294967296;

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_COUNT_SCALE        = 1'b0,
      CSR_INVERSE_WHEEL_BASE = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MUL_LEFT,
      ST_MUL_RIGHT,
      ST_SIDE,
      ST_SUM,
      ST_TURN_LO,
      ST_TURN_HI,
      ST_TURN_ACC,
      ST_MID,
      ST_ROTATE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_POS_Y,
      ST_OUT
   } state_type;

   // Operand pair for the shared multiplier
   typedef enum logic [2:0] {
      MUL_LEFT,
      MUL_RIGHT,
      MUL_TURN_LO,
      MUL_TURN_HI,
      MUL_POS_X,
      MUL_POS_Y
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        delta;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        latch_left;
      logic        latch_right;
      logic        sum;
      logic        latch_acc;
      logic        latch_turn;
      logic        rot_init;
      logic        rot_step;
      logic        update_x;
      logic        update_y;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic rotate_last;
   } status_type;

   // Arctangent of 2^-i in binary-angle units, rounded to nearest
   function automatic logic [29:0] atan_unit(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10680862;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         5'd31: v = 30'd0;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ddo_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] count_left_front;
   logic signed [31:0] count_right_front;
   logic signed [31:0] count_left_rear;
   logic signed [31:0] count_right_rear;

   modport source (
      output valid, count_left_front, count_right_front, count_left_rear, count_right_rear,
      input  ready
   );
   modport sink (
      input  valid, count_left_front, count_right_front, count_left_rear, count_right_rear,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/ddo_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;

   modport source (
      output valid, pos_x, pos_y, heading,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, heading,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/ddo_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_controller (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  ddo_pkg::status_type status,
   output ddo_pkg::cmd_type    cmd
);
   import ddo_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DELTA;
         ST_DELTA:     state_in = ST_MUL_LEFT;
         ST_MUL_LEFT:  state_in = ST_MUL_RIGHT;
         ST_MUL_RIGHT: state_in = ST_SIDE;
         ST_SIDE:      state_in = ST_SUM;
         ST_SUM:       state_in = ST_TURN_LO;
         ST_TURN_LO:   state_in = ST_TURN_HI;
         ST_TURN_HI:   state_in = ST_TURN_ACC;
         ST_TURN_ACC:  state_in = ST_MID;
         ST_MID:       state_in = ST_ROTATE;
         ST_ROTATE:    if (status.rotate_last) state_in = ST_MUL_X;
         ST_MUL_X:     state_in = ST_MUL_Y;
         ST_MUL_Y:     state_in = ST_POS_Y;
         ST_POS_Y:     state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DELTA: cmd.delta = 1'b1;
         ST_MUL_LEFT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LEFT;
         end
         ST_MUL_RIGHT: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_RIGHT;
            cmd.latch_left = 1'b1;
         end
         ST_SIDE: cmd.latch_right = 1'b1;
         ST_SUM:  cmd.sum = 1'b1;
         ST_TURN_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TURN_LO;
         end
         ST_TURN_HI: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_TURN_HI;
            cmd.latch_acc = 1'b1;
         end
         ST_TURN_ACC: cmd.latch_turn = 1'b1;
         ST_MID:      cmd.rot_init = 1'b1;
         ST_ROTATE:   cmd.rot_step = 1'b1;
         ST_MUL_X: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_POS_X;
         end
         ST_MUL_Y: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_POS_Y;
            cmd.update_x = 1'b1;
         end
         ST_POS_Y: cmd.update_y = 1'b1;
         ST_OUT:   cmd.load_out = out_free;
         default:  cmd = '0;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ddo_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_datapath #(
   parameter int CORDIC_STEPS = 24,
   parameter int COUNT_WIDTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  ddo_pkg::csr_index_type  csr_index,
   input  wire logic [31:0]        csr_write_data,
   input  ddo_pkg::cmd_type        cmd,
   output ddo_pkg::status_type     status,
   input  wire logic signed [31:0] count_left_front,
   input  wire logic signed [31:0] count_right_front,
   input  wire logic signed [31:0] count_left_rear,
   input  wire logic signed [31:0] count_right_rear,
   output logic signed [31:0]      pos_x,
   output logic signed [31:0]      pos_y,
   output logic signed [31:0]      heading
);
   import ddo_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int CW     = COUNT_WIDTH;

   localparam logic signed [38:0] POS_MAX = 39'sd2147483647;
   localparam logic signed [38:0] POS_MIN = -39'sd2147483648;

   // Saturating add of a position step
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [37:0] s);
      logic signed [38:0] r;
      r = {{7{p[31]}}, p} + {s[37], s};
      if (r > POS_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (r < POS_MIN) begin
         return 32'sh8000_0000;
      end
      return r[31:0];
   endfunction

   // Configuration and pose state
   logic [31:0]        dpc_ff, dpc_in;
   logic [31:0]        ib_ff, ib_in;
   logic [CW-1:0]      prev_ff [4];
   logic [CW-1:0]      prev_in [4];
   logic signed [31:0] px_ff, px_in;
   logic signed [31:0] py_ff, py_in;
   logic [31:0]        hd_ff, hd_in;

   // Working registers
   logic [CW-1:0]            now_ff [4];
   logic [CW-1:0]            now_in [4];
   logic signed [CW-1:0]     left_d_ff, left_d_in;
   logic signed [CW-1:0]     right_d_ff, right_d_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [48:0]       left_m_ff, left_m_in;
   logic signed [48:0]       right_m_ff, right_m_in;
   logic signed [49:0]       diff_ff, diff_in;
   logic signed [33:0]       dist_ff, dist_in;
   logic [63:0]              acc_ff, acc_in;
   logic [31:0]              turn_ff, turn_in;
   logic signed [33:0]       x_ff, x_in;
   logic signed [33:0]       y_ff, y_in;
   logic signed [33:0]       z_ff, z_in;
   logic                     flip_ff, flip_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [31:0]       out_x_ff, out_x_in;
   logic signed [31:0]       out_y_ff, out_y_in;
   logic [31:0]              out_h_ff, out_h_in;

   // Combinational helpers
   logic [31:0]              count_now [4];
   logic [CW-1:0]            wheel_d [4];
   logic signed [CW:0]       left_sum, right_sum, left_adj, right_adj;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_full;
   logic signed [MUL_W-1:0]  cos_val, sin_val;
   logic signed [49:0]       side_sum;
   logic signed [48:0]       dist_half, dist_clamped;
   logic [63:0]              turn_sum;
   logic [31:0]              half_turn, mid;
   logic                     mid_far;
   logic signed [33:0]       x_sh, y_sh, atan_val;

   assign count_now[0] = count_left_front;
   assign count_now[1] = count_right_front;
   assign count_now[2] = count_left_rear;
   assign count_now[3] = count_right_rear;

   // Wheel deltas modulo the counter width, side sums halved toward zero
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         wheel_d[k] = now_ff[k] - prev_ff[k];
      end
      left_sum  = {wheel_d[0][CW-1], wheel_d[0]} + {wheel_d[2][CW-1], wheel_d[2]};
      right_sum = {wheel_d[1][CW-1], wheel_d[1]} + {wheel_d[3][CW-1], wheel_d[3]};
      left_adj  = left_sum + {{CW{1'b0}}, left_sum[CW]};
      right_adj = right_sum + {{CW{1'b0}}, right_sum[CW]};
   end

   // CORDIC outputs, undoing the half-turn fold
   assign cos_val = flip_ff ? -x_ff : x_ff;
   assign sin_val = flip_ff ? -y_ff : y_ff;

   // Shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_LEFT: begin
            mul_a = {{(MUL_W-CW){left_d_ff[CW-1]}}, left_d_ff};
            mul_b = {2'b00, dpc_ff};
         end
         MUL_RIGHT: begin
            mul_a = {{(MUL_W-CW){right_d_ff[CW-1]}}, right_d_ff};
            mul_b = {2'b00, dpc_ff};
         end
         MUL_TURN_LO: begin
            mul_a = {9'b0, diff_ff[24:0]};
            mul_b = {2'b00, ib_ff};
         end
         MUL_TURN_HI: begin
            mul_a = {{9{diff_ff[49]}}, diff_ff[49:25]};
            mul_b = {2'b00, ib_ff};
         end
         MUL_POS_X: begin
            mul_a = dist_ff;
            mul_b = cos_val;
         end
         MUL_POS_Y: begin
            mul_a = dist_ff;
            mul_b = sin_val;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Distance and heading change terms
   assign side_sum     = {left_m_ff[48], left_m_ff} + {right_m_ff[48], right_m_ff};
   assign dist_half    = side_sum[49:1];
   assign dist_clamped = (dist_half > DIST_HI) ? DIST_HI :
                         (dist_half < DIST_LO) ? DIST_LO : dist_half;
   assign turn_sum     = acc_ff + {prod_ff[38:0], 25'b0};

   // Mid-step angle and fold into the right half plane
   assign half_turn = {turn_ff[31], turn_ff[31:1]};
   assign mid       = hd_ff + half_turn;
   assign mid_far   = ($signed(mid) > QUARTER_TURN) || ($signed(mid) < NEG_QUARTER_TURN);

   // One CORDIC rotation
   assign x_sh     = x_ff >>> step_ff;
   assign y_sh     = y_ff >>> step_ff;
   assign atan_val = {4'b0, atan_unit(5'(step_ff))};

   assign status.rotate_last = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   // Next values
   always_comb begin
      dpc_in     = dpc_ff;
      ib_in      = ib_ff;
      prev_in    = prev_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      hd_in      = hd_ff;
      now_in     = now_ff;
      left_d_in  = left_d_ff;
      right_d_in = right_d_ff;
      prod_in    = prod_ff;
      left_m_in  = left_m_ff;
      right_m_in = right_m_ff;
      diff_in    = diff_ff;
      dist_in    = dist_ff;
      acc_in     = acc_ff;
      turn_in    = turn_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      flip_in    = flip_ff;
      step_in    = step_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_h_in   = out_h_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_COUNT_SCALE:        dpc_in = csr_write_data;
            CSR_INVERSE_WHEEL_BASE: ib_in  = csr_write_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         for (int k = 0; k < 4; k++) begin
            now_in[k] = count_now[k][CW-1:0];
         end
      end

      if (cmd.delta) begin
         left_d_in  = left_adj[CW:1];
         right_d_in = right_adj[CW:1];
         prev_in    = now_ff;
      end

      if (cmd.mul_en) begin
         prod_in = mul_full;
      end
      if (cmd.latch_left) begin
         left_m_in = prod_ff[64:16];
      end
      if (cmd.latch_right) begin
         right_m_in = prod_ff[64:16];
      end

      if (cmd.sum) begin
         diff_in = {right_m_ff[48], right_m_ff} - {left_m_ff[48], left_m_ff};
         dist_in = dist_clamped[33:0];
      end

      if (cmd.latch_acc) begin
         acc_in = prod_ff[63:0];
      end
      if (cmd.latch_turn) begin
         turn_in = turn_sum[63:32];
      end

      if (cmd.rot_init) begin
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         flip_in = mid_far;
         step_in = '0;
         if (mid_far) begin
            z_in = {{2{~mid[31]}}, ~mid[31], mid[30:0]};
         end else begin
            z_in = {{2{mid[31]}}, mid};
         end
      end

      if (cmd.rot_step) begin
         if (!z_ff[33]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_val;
         end
         step_in = step_ff + STEP_W'(1);
      end

      if (cmd.update_x) begin
         px_in = sat_add(px_ff, prod_ff[67:30]);
      end
      if (cmd.update_y) begin
         py_in = sat_add(py_ff, prod_ff[67:30]);
         hd_in = hd_ff + turn_ff;
      end

      if (cmd.load_out) begin
         out_x_in = px_ff;
         out_y_in = py_ff;
         out_h_in = hd_ff;
      end
   end

   // Pose and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= '0;
         ib_ff  <= '0;
         for (int k = 0; k < 4; k++) begin
            prev_ff[k] <= '0;
         end
         px_ff <= '0;
         py_ff <= '0;
         hd_ff <= '0;
      end else begin
         dpc_ff  <= dpc_in;
         ib_ff   <= ib_in;
         prev_ff <= prev_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         hd_ff   <= hd_in;
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      left_d_ff  <= left_d_in;
      right_d_ff <= right_d_in;
      prod_ff    <= prod_in;
      left_m_ff  <= left_m_in;
      right_m_ff <= right_m_in;
      diff_ff    <= diff_in;
      dist_ff    <= dist_in;
      acc_ff     <= acc_in;
      turn_ff    <= turn_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      flip_ff    <= flip_in;
      step_ff    <= step_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_h_ff   <= out_h_in;
   end

   assign pos_x   = out_x_ff;
   assign pos_y   = out_y_ff;
   assign heading = $signed(out_h_ff);

endmodule

`default_nettype wire

FILE: hdl/differential_drive_odometry.sv
// Differential-drive odometry. Each transaction on req_chan carries four absolute
// encoder counts (left front, right front, left rear, right rear); the block
// differences them against the previous sample modulo 2^COUNT_WIDTH, converts
// the side averages to metres with the metres-per-count register, turns the side
// difference into a heading change with inverse_wheel_base, and advances x/y
// along the mid-step heading using an iterative CORDIC. One transaction on
// rsp_chan returns the new pose: Q16.16 position (saturating) and a 32-bit
// binary-angle heading (wrapping). The time an item occupies the block, from
// acceptance until req_chan.ready returns, is set by the CORDIC, which does one
// rotation per cycle, by the single 34x34 multiplier that is used six times per
// item, and by any wait for the output register to come free. The result sits
// in an output register, so the next item is taken while it waits. Registers must
// be written through csr_* only while the block is idle; the block itself does
// not enforce this. Both reset to zero, which leaves the pose unchanged.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry #(
   parameter int CORDIC_STEPS = 24,
   parameter int COUNT_WIDTH  = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   ddo_req_if.sink                req_chan,
   ddo_rsp_if.source              rsp_chan,
   input  wire logic              csr_write_enable,
   input  ddo_pkg::csr_index_type csr_index,
   input  wire logic [31:0]       csr_write_data
);
   import ddo_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   ddo_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state
   ddo_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .count_left_front  (req_chan.count_left_front),
      .count_right_front (req_chan.count_right_front),
      .count_left_rear   (req_chan.count_left_rear),
      .count_right_rear  (req_chan.count_right_rear),
      .pos_x             (rsp_chan.pos_x),
      .pos_y             (rsp_chan.pos_y),
      .heading           (rsp_chan.heading)
   );

endmodule

`default_nettype wire

FILE: hdl/ddo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] pos_x,
   input wire logic [31:0] pos_y,
   input wire logic [31:0] heading
);

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading))
      else $error("result changed while stalled");

   // One item at a time: busy right after a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   // A result never appears the cycle after an input transaction
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pos_x     (rsp_chan.pos_x),
   .pos_y     (rsp_chan.pos_y),
   .heading   (rsp_chan.heading)
);

`default_nettype wire
